@@ rtl/vqdm_pkg.sv @@
// Shared constants and command types for the split virtqueue descriptor manager.
// No dependencies; used by every module of the block.
package vqdm_pkg;

   localparam int DEF_QUEUE_DEPTH = 256;

   localparam logic [15:0] LINK_END = 16'hFFFF;

   localparam logic [1:0] KIND_ALLOC    = 2'd0;
   localparam logic [1:0] KIND_PUBLISH  = 2'd1;
   localparam logic [1:0] KIND_COMPLETE = 2'd2;
   localparam logic [1:0] KIND_POP      = 2'd3;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_ADDR_W-1:0] CSR_QSIZE_LOG2  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_QUEUE_NUM   = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_NOTIFY_OFS  = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_NOTIFY_MULT = 2'd3;

   localparam logic [3:0] RST_QSIZE_LOG2 = 4'd8;

   localparam int REQ_DATA_W = 120;
   localparam int RSP_DATA_W = 104;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic buf_wr_en;
   } desc_cmd_type;

   typedef struct packed {
      logic avail_wr_en;
      logic used_wr_en;
      logic used_rd_en;
   } ring_cmd_type;

endpackage

@@ rtl/vqdm_desc_table.sv @@
// Descriptor table: link memory with its init sweep, and the buffer descriptor memory.
// Depends on vqdm_pkg.
module vqdm_desc_table #(
   parameter int QUEUE_DEPTH = vqdm_pkg::DEF_QUEUE_DEPTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               init_start,
   input  logic [$clog2(QUEUE_DEPTH+1)-1:0]   ring_size,
   input  vqdm_pkg::desc_cmd_type             cmd,
   input  logic [$clog2(QUEUE_DEPTH)-1:0]     rd_addr,
   output logic [15:0]                        rd_link,
   input  logic [$clog2(QUEUE_DEPTH)-1:0]     wr_addr,
   input  logic [15:0]                        wr_link,
   input  logic [63:0]                        wr_buf_addr,
   input  logic [31:0]                        wr_buf_len,
   input  logic [15:0]                        wr_buf_flags,
   output logic                               init_busy
);
   localparam int IDW  = $clog2(QUEUE_DEPTH);
   localparam int CNTW = $clog2(QUEUE_DEPTH+1);

   logic [15:0]      link_mem [QUEUE_DEPTH];
   logic [111:0]     buf_mem  [QUEUE_DEPTH];

   logic             init_busy_ff, init_busy_in;
   logic [IDW-1:0]   init_ptr_ff, init_ptr_in;
   logic [15:0]      rd_link_ff;
   logic [CNTW-1:0]  sweep_next;
   logic [15:0]      sweep_link;

   always_comb begin
      sweep_next = CNTW'(init_ptr_ff) + CNTW'(1);
      sweep_link = (sweep_next < ring_size) ? 16'(sweep_next) : vqdm_pkg::LINK_END;
      init_busy_in = init_busy_ff;
      init_ptr_in  = init_ptr_ff;
      if (init_start) begin
         init_busy_in = 1'b1;
         init_ptr_in  = '0;
      end else if (init_busy_ff) begin
         init_ptr_in = init_ptr_ff + IDW'(1);
         if (init_ptr_ff == IDW'(QUEUE_DEPTH - 1)) begin
            init_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_busy_ff <= 1'b1;
         init_ptr_ff  <= '0;
      end else begin
         init_busy_ff <= init_busy_in;
         init_ptr_ff  <= init_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (init_busy_ff) begin
         link_mem[init_ptr_ff] <= sweep_link;
      end else if (cmd.wr_en) begin
         link_mem[wr_addr] <= wr_link;
      end
      if (cmd.rd_en) begin
         rd_link_ff <= link_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.buf_wr_en) begin
         buf_mem[wr_addr] <= {wr_buf_addr, wr_buf_len, wr_buf_flags};
      end
   end

   assign rd_link   = rd_link_ff;
   assign init_busy = init_busy_ff;

endmodule

@@ rtl/vqdm_ring_store.sv @@
// Available ring and used ring memories (id and length), with registered reads of the used ring.
// Depends on vqdm_pkg.
module vqdm_ring_store #(
   parameter int QUEUE_DEPTH = vqdm_pkg::DEF_QUEUE_DEPTH
) (
   input  logic                           clock,
   input  vqdm_pkg::ring_cmd_type         cmd,
   input  logic [$clog2(QUEUE_DEPTH)-1:0] avail_addr,
   input  logic [$clog2(QUEUE_DEPTH)-1:0] avail_id,
   input  logic [$clog2(QUEUE_DEPTH)-1:0] used_wr_addr,
   input  logic [$clog2(QUEUE_DEPTH)-1:0] used_wr_id,
   input  logic [31:0]                    used_wr_len,
   input  logic [$clog2(QUEUE_DEPTH)-1:0] used_rd_addr,
   output logic [$clog2(QUEUE_DEPTH)-1:0] used_rd_id,
   output logic [31:0]                    used_rd_len
);
   localparam int IDW = $clog2(QUEUE_DEPTH);

   logic [IDW-1:0] avail_mem   [QUEUE_DEPTH];
   logic [IDW-1:0] used_id_mem [QUEUE_DEPTH];
   logic [31:0]    used_len_mem[QUEUE_DEPTH];

   logic [IDW-1:0] used_rd_id_ff;
   logic [31:0]    used_rd_len_ff;

   always_ff @(posedge clock) begin
      if (cmd.avail_wr_en) begin
         avail_mem[avail_addr] <= avail_id;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.used_wr_en) begin
         used_id_mem[used_wr_addr]  <= used_wr_id;
         used_len_mem[used_wr_addr] <= used_wr_len;
      end
      if (cmd.used_rd_en) begin
         used_rd_id_ff  <= used_id_mem[used_rd_addr];
         used_rd_len_ff <= used_len_mem[used_rd_addr];
      end
   end

   assign used_rd_id  = used_rd_id_ff;
   assign used_rd_len = used_rd_len_ff;

endmodule

@@ rtl/virtqueue_descriptor_manager_top.sv @@
// Top level of the split virtqueue descriptor manager: config registers, ring indices,
// operation sequencer and result register. Depends on vqdm_pkg, vqdm_desc_table,
// vqdm_ring_store.
//
//   channel  direction  handshake              payload
//   req_     in         req_tvalid/req_tready  tdata: buf_addr, buf_len, buf_flags, desc_id
//                                              tuser: kind
//   rsp_     out        rsp_tvalid/rsp_tready  tdata: desc_index, done_len, doorbell_offset,
//                                              doorbell_value, free_count; tuser: ok, doorbell
//   csr_     in         csr_we                 csr_addr, csr_wdata
//
// Each item runs as accept then execute: the accept issues the link and used-ring reads,
// and the execute state applies the read-modify-write and loads the result register.
// After reset and after each queue_size_log2 write the link memory is swept over all
// QUEUE_DEPTH entries; req_tready stays low meanwhile.
// A waiting result does not block the next accept; the execute cycle waits for the
// result register to drain.
module virtqueue_descriptor_manager_top #(
   parameter int QUEUE_DEPTH = vqdm_pkg::DEF_QUEUE_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [vqdm_pkg::REQ_DATA_W-1:0]   req_tdata,  // buf_addr, buf_len, buf_flags, desc_id
   input  logic [1:0]                        req_tuser,  // kind
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [vqdm_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // desc_index, done_len,
                                                         // doorbell_offset, doorbell_value,
                                                         // free_count, zero pad
   output logic [1:0]                        rsp_tuser,  // ok, doorbell
   input  logic                              csr_we,
   input  logic [vqdm_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [vqdm_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   localparam int IDW  = $clog2(QUEUE_DEPTH);
   localparam int CNTW = $clog2(QUEUE_DEPTH+1);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   function automatic logic [CNTW-1:0] size_of(input logic [3:0] lg);
      logic [3:0]      eff;
      logic [16:0]     full;
      logic [CNTW-1:0] sz;
      eff  = (lg == 4'd0) ? 4'd1 : lg;
      full = 17'd1 << eff;
      sz   = (full > 17'(QUEUE_DEPTH)) ? CNTW'(QUEUE_DEPTH) : CNTW'(full);
      return sz;
   endfunction

   logic            state_ff, state_in;
   logic [3:0]      qsize_lg_ff, qsize_lg_in;
   logic [15:0]     queue_num_ff, queue_num_in;
   logic [15:0]     ntf_offset_ff, ntf_offset_in;
   logic [15:0]     notify_mult_ff, notify_mult_in;
   logic [31:0]     bell_off_ff;
   logic [15:0]     list_top_ff, list_top_in;
   logic [CNTW-1:0] free_total_ff, free_total_in;
   logic [15:0]     avail_idx_ff, avail_idx_in;
   logic [15:0]     used_idx_ff, used_idx_in;
   logic [15:0]     last_seen_ff, last_seen_in;

   logic [1:0]      kind_ff;
   logic [63:0]     addr_ff;
   logic [31:0]     len_ff;
   logic [15:0]     flags_ff;
   logic [IDW-1:0]  id_ff;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [vqdm_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [1:0]                  rsp_user_ff, rsp_user_in;

   logic            init_busy;
   logic            accept;
   logic            exec_fire;
   logic            qsize_wr;
   logic [CNTW-1:0] ring_size;
   logic [IDW-1:0]  ring_mask;

   vqdm_pkg::desc_cmd_type desc_cmd;
   vqdm_pkg::ring_cmd_type ring_cmd;
   logic [15:0]     link_rd;
   logic [IDW-1:0]  desc_wr_addr;
   logic [15:0]     desc_wr_link;
   logic [IDW-1:0]  used_rd_id;
   logic [31:0]     used_rd_len;

   logic            res_ok;
   logic            res_bell;
   logic [7:0]      res_idx;
   logic [31:0]     res_len;
   logic [31:0]     res_boff;
   logic [15:0]     res_bval;

   assign ring_size  = size_of(qsize_lg_ff);
   assign ring_mask  = IDW'(ring_size - CNTW'(1));
   assign req_tready = (state_ff == ST_IDLE) && !init_busy;
   assign accept     = req_tvalid && req_tready;
   assign exec_fire  = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_tready);
   assign qsize_wr   = csr_we && (csr_addr == vqdm_pkg::CSR_QSIZE_LOG2);

   always_comb begin
      desc_cmd       = '0;
      ring_cmd       = '0;
      desc_cmd.rd_en = accept;
      ring_cmd.used_rd_en = accept;
      desc_wr_addr   = list_top_ff[IDW-1:0];
      desc_wr_link   = 16'd0;
      list_top_in    = list_top_ff;
      free_total_in  = free_total_ff;
      avail_idx_in   = avail_idx_ff;
      used_idx_in    = used_idx_ff;
      last_seen_in   = last_seen_ff;
      res_ok         = 1'b0;
      res_bell       = 1'b0;
      res_idx        = 8'd0;
      res_len        = 32'd0;
      res_boff       = 32'd0;
      res_bval       = 16'd0;
      if (state_ff == ST_EXEC) begin
         case (kind_ff)
            vqdm_pkg::KIND_ALLOC: begin
               if (free_total_ff != '0 && list_top_ff < 16'(QUEUE_DEPTH)) begin
                  desc_cmd.wr_en     = exec_fire;
                  desc_cmd.buf_wr_en = exec_fire;
                  list_top_in        = link_rd;
                  free_total_in      = free_total_ff - CNTW'(1);
                  res_ok             = 1'b1;
                  res_idx            = 8'(list_top_ff);
               end
            end
            vqdm_pkg::KIND_PUBLISH: begin
               ring_cmd.avail_wr_en = exec_fire;
               avail_idx_in         = avail_idx_ff + 16'd1;
               res_ok               = 1'b1;
               res_bell             = 1'b1;
               res_boff             = bell_off_ff;
               res_bval             = queue_num_ff;
            end
            vqdm_pkg::KIND_COMPLETE: begin
               ring_cmd.used_wr_en = exec_fire;
               used_idx_in         = used_idx_ff + 16'd1;
               res_ok              = 1'b1;
            end
            vqdm_pkg::KIND_POP: begin
               if (last_seen_ff != used_idx_ff) begin
                  desc_cmd.wr_en = exec_fire;
                  desc_wr_addr   = used_rd_id;
                  desc_wr_link   = list_top_ff;
                  list_top_in    = 16'(used_rd_id);
                  if (free_total_ff < CNTW'(QUEUE_DEPTH)) begin
                     free_total_in = free_total_ff + CNTW'(1);
                  end
                  last_seen_in = last_seen_ff + 16'd1;
                  res_ok       = 1'b1;
                  res_idx      = 8'(used_rd_id);
                  res_len      = used_rd_len;
               end
            end
            default: begin
            end
         endcase
      end
      if (!exec_fire) begin
         list_top_in   = list_top_ff;
         free_total_in = free_total_ff;
         avail_idx_in  = avail_idx_ff;
         used_idx_in   = used_idx_ff;
         last_seen_in  = last_seen_ff;
      end
      if (qsize_wr) begin
         list_top_in   = 16'd0;
         free_total_in = size_of(csr_wdata[3:0]);
         avail_idx_in  = 16'd0;
         used_idx_in   = 16'd0;
         last_seen_in  = 16'd0;
      end
   end

   always_comb begin
      qsize_lg_in    = qsize_lg_ff;
      queue_num_in   = queue_num_ff;
      ntf_offset_in  = ntf_offset_ff;
      notify_mult_in = notify_mult_ff;
      if (csr_we) begin
         case (csr_addr)
            vqdm_pkg::CSR_QSIZE_LOG2:  qsize_lg_in    = csr_wdata[3:0];
            vqdm_pkg::CSR_QUEUE_NUM:   queue_num_in   = csr_wdata;
            vqdm_pkg::CSR_NOTIFY_OFS:  ntf_offset_in  = csr_wdata;
            vqdm_pkg::CSR_NOTIFY_MULT: notify_mult_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (accept) state_in = ST_EXEC;
         ST_EXEC: if (exec_fire) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (exec_fire) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {7'd0, 9'(free_total_in), res_bval, res_boff, res_len, res_idx};
         rsp_user_in  = {res_bell, res_ok};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         qsize_lg_ff    <= vqdm_pkg::RST_QSIZE_LOG2;
         queue_num_ff   <= 16'd0;
         ntf_offset_ff  <= 16'd0;
         notify_mult_ff <= 16'd0;
         list_top_ff    <= 16'd0;
         free_total_ff  <= size_of(vqdm_pkg::RST_QSIZE_LOG2);
         avail_idx_ff   <= 16'd0;
         used_idx_ff    <= 16'd0;
         last_seen_ff   <= 16'd0;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         qsize_lg_ff    <= qsize_lg_in;
         queue_num_ff   <= queue_num_in;
         ntf_offset_ff  <= ntf_offset_in;
         notify_mult_ff <= notify_mult_in;
         list_top_ff    <= list_top_in;
         free_total_ff  <= free_total_in;
         avail_idx_ff   <= avail_idx_in;
         used_idx_ff    <= used_idx_in;
         last_seen_ff   <= last_seen_in;
      end
   end

   always_ff @(posedge clock) begin
      bell_off_ff <= 32'(ntf_offset_ff) * 32'(notify_mult_ff);
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      if (accept) begin
         kind_ff  <= req_tuser;
         addr_ff  <= req_tdata[63:0];
         len_ff   <= req_tdata[95:64];
         flags_ff <= req_tdata[111:96];
         id_ff    <= IDW'(req_tdata[119:112]);
      end
   end

   vqdm_desc_table #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_desc_table (
      .clock        (clock),
      .reset        (reset),
      .init_start   (qsize_wr),
      .ring_size    (ring_size),
      .cmd          (desc_cmd),
      .rd_addr      (list_top_ff[IDW-1:0]),
      .rd_link      (link_rd),
      .wr_addr      (desc_wr_addr),
      .wr_link      (desc_wr_link),
      .wr_buf_addr  (addr_ff),
      .wr_buf_len   (len_ff),
      .wr_buf_flags (flags_ff),
      .init_busy    (init_busy)
   );

   vqdm_ring_store #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_ring_store (
      .clock        (clock),
      .cmd          (ring_cmd),
      .avail_addr   (avail_idx_ff[IDW-1:0] & ring_mask),
      .avail_id     (id_ff),
      .used_wr_addr (used_idx_ff[IDW-1:0] & ring_mask),
      .used_wr_id   (id_ff),
      .used_wr_len  (len_ff),
      .used_rd_addr (last_seen_ff[IDW-1:0] & ring_mask),
      .used_rd_id   (used_rd_id),
      .used_rd_len  (used_rd_len)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

@@ rtl/vqdm_checker.sv @@
// Port-level checker for the virtqueue descriptor manager, bound to the top level.
// Depends on vqdm_pkg and virtqueue_descriptor_manager_top.
module vqdm_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [vqdm_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input logic [1:0]                        rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   a_reset_sweep: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("item accepted during link sweep");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second item accepted while one is in flight");

   a_bell_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tuser[0])
      else $error("doorbell without success");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[39:0] == 40'd0)
      else $error("failed item carries index or length");

endmodule

bind virtqueue_descriptor_manager_top vqdm_checker u_vqdm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
